[sv/csfl_pkg.sv]
// shared types, constants and greeting table for the checksummed frame link master
`default_nettype none

package csfl_pkg;

    // frame sizes
    localparam int TX_LEN      = 8;
    localparam int RX_LEN      = 12;
    localparam int GREET_LEN   = 48;
    localparam int FRAME_DEPTH = 64;
    localparam int FRAME_AW    = $clog2(FRAME_DEPTH);
    localparam int TX_IW       = (TX_LEN > 1) ? $clog2(TX_LEN) : 1;

    localparam logic [FRAME_AW-1:0] TX_LEN_W    = FRAME_AW'(TX_LEN);
    localparam logic [FRAME_AW-1:0] GREET_LEN_W = FRAME_AW'(GREET_LEN);
    localparam logic [FRAME_AW-1:0] RX_TOTAL    = FRAME_AW'(RX_LEN + 1);
    localparam logic [FRAME_AW-1:0] RX_LAST     = FRAME_AW'(RX_LEN - 1);

    // field widths
    localparam int OP_W   = 2;
    localparam int IDX_W  = 5;
    localparam int BYTE_W = 8;
    localparam int ADDR_W = 7;
    localparam int ACT_W  = 3;

    // input operation codes
    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_REQ    = 2'd1,
        OP_TXRDY  = 2'd2,
        OP_RXBYTE = 2'd3
    } t_op;

    // result action codes
    typedef enum logic [ACT_W-1:0] {
        ACT_NONE        = 3'd0,
        ACT_START_WRITE = 3'd1,
        ACT_SEND        = 3'd2,
        ACT_START_READ  = 3'd3,
        ACT_DELIVER     = 3'd4,
        ACT_REJECT      = 3'd5,
        ACT_DONE        = 3'd6
    } t_act;

    // link phase
    typedef enum logic [2:0] {
        PH_GREET     = 3'd0,
        PH_WRITE     = 3'd1,
        PH_SENDING   = 3'd2,
        PH_READ      = 3'd3,
        PH_RECEIVING = 3'd4
    } t_phase;

    // sequencer state
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COPY,
        ST_CKSUM,
        ST_EMIT,
        ST_DELIV,
        ST_DLOUT
    } t_state;

    // shared accumulator operations
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_CLR,
        ACC_ADD,
        ACC_ADD_INV
    } t_acc_op;

    typedef struct packed {
        t_acc_op           op;
        logic [BYTE_W-1:0] operand;
    } t_acc_cmd;

    // frame buffer port request
    typedef struct packed {
        logic                we;
        logic [FRAME_AW-1:0] waddr;
        logic [BYTE_W-1:0]   wdata;
        logic                re;
        logic [FRAME_AW-1:0] raddr;
    } t_ram_req;

    // greeting frame payload, trailing zero included
    localparam logic [BYTE_W-1:0] GREETING [GREET_LEN] = '{
        8'hCC,
        8'h4C, 8'h65, 8'h74, 8'h27, 8'h73, 8'h20,
        8'h73, 8'h61, 8'h6D, 8'h62, 8'h61, 8'h20,
        8'h6E, 8'h78, 8'h74, 8'h20,
        8'h61, 8'h72, 8'h6D, 8'h20,
        8'h69, 8'h6E, 8'h20,
        8'h61, 8'h72, 8'h6D, 8'h2C, 8'h20,
        8'h28, 8'h63, 8'h29, 8'h4C, 8'h45, 8'h47, 8'h4F, 8'h20,
        8'h53, 8'h79, 8'h73, 8'h74, 8'h65, 8'h6D, 8'h20,
        8'h41, 8'h2F, 8'h53, 8'h00
    };

endpackage

`default_nettype wire

[sv/csfl_frame_ram.sv]
// frame buffer memory: one write port, one registered read port
`default_nettype none

module csfl_frame_ram
    import csfl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_ram_req          i_req,
    output logic      [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] r_mem [FRAME_DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // registered read, holds between reads
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[sv/csfl_accum.sv]
// shared 8-bit checksum accumulator
`default_nettype none

module csfl_accum
    import csfl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_acc_cmd          i_cmd,
    output logic      [BYTE_W-1:0] o_sum
);

    logic [BYTE_W-1:0] r_sum;
    logic [BYTE_W-1:0] n_sum;
    logic [BYTE_W-1:0] add_res;

    // the one adder of the block
    assign add_res = r_sum + i_cmd.operand;

    always_comb begin
        case (i_cmd.op)
            ACC_CLR:     n_sum = '0;
            ACC_ADD:     n_sum = add_res;
            ACC_ADD_INV: n_sum = ~add_res;
            default:     n_sum = r_sum;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

`default_nettype wire

[sv/csfl_ctrl.sv]
// link sequencer: phase tracking, frame copy, send, receive, delivery and result register
`default_nettype none

module csfl_ctrl
    import csfl_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // input beat
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire t_op                 i_op,
    input  wire logic [IDX_W-1:0]    i_index,
    input  wire logic [BYTE_W-1:0]   i_data,
    // configuration
    input  wire logic [ADDR_W-1:0]   i_dev_addr,
    // shared units
    output t_acc_cmd                 o_acc_cmd,
    input  wire logic [BYTE_W-1:0]   i_acc_sum,
    output t_ram_req                 o_ram_req,
    input  wire logic [BYTE_W-1:0]   i_ram_rdata,
    // result beat
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output t_act                     o_action,
    output logic      [ADDR_W-1:0]   o_bus_address,
    output logic      [BYTE_W-1:0]   o_byte_out,
    output logic                     o_stop_request,
    output logic                     o_last
);

    // sequencer and link state
    t_state              r_state, n_state;
    t_phase              r_phase, n_phase;
    logic [FRAME_AW-1:0] r_bc, n_bc;
    logic [FRAME_AW-1:0] r_ft, n_ft;
    logic [FRAME_AW-1:0] r_cnt, n_cnt;
    logic [FRAME_AW-1:0] r_len, n_len;
    logic                r_is_greet, n_is_greet;

    // pending single result
    t_act                r_p_act, n_p_act;
    logic                r_p_addr, n_p_addr;
    logic                r_p_ram, n_p_ram;
    logic                r_p_stop, n_p_stop;

    // result register
    logic                r_o_valid, n_o_valid;
    t_act                r_o_act, n_o_act;
    logic [ADDR_W-1:0]   r_o_addr, n_o_addr;
    logic [BYTE_W-1:0]   r_o_byte, n_o_byte;
    logic                r_o_stop, n_o_stop;
    logic                r_o_last, n_o_last;

    // outgoing payload store
    logic [BYTE_W-1:0]   r_payload [TX_LEN];
    logic                pl_we;

    logic                in_fire;
    logic                out_free;
    logic                out_load;
    logic [FRAME_AW:0]   bc_p1;
    logic [FRAME_AW:0]   bc_p2;
    logic [FRAME_AW:0]   ft_x;
    logic [BYTE_W-1:0]   src_byte;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_o_valid || i_out_ready;
    assign bc_p1    = {1'b0, r_bc} + (FRAME_AW+1)'(1);
    assign bc_p2    = {1'b0, r_bc} + (FRAME_AW+1)'(2);
    assign ft_x     = {1'b0, r_ft};
    assign src_byte = r_is_greet ? GREETING[r_cnt] : r_payload[r_cnt[TX_IW-1:0]];

    // next state and unit commands
    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_bc       = r_bc;
        n_ft       = r_ft;
        n_cnt      = r_cnt;
        n_len      = r_len;
        n_is_greet = r_is_greet;
        n_p_act    = r_p_act;
        n_p_addr   = r_p_addr;
        n_p_ram    = r_p_ram;
        n_p_stop   = r_p_stop;
        o_in_ready = (r_state == ST_IDLE);
        o_acc_cmd  = '{op: ACC_HOLD, operand: '0};
        o_ram_req  = '0;
        pl_we      = 1'b0;
        out_load   = 1'b0;
        n_o_act    = ACT_NONE;
        n_o_addr   = '0;
        n_o_byte   = '0;
        n_o_stop   = 1'b0;
        n_o_last   = 1'b1;

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    case (i_op)
                        OP_LOAD: begin
                            pl_we = ({1'b0, i_index} < TX_LEN_W);
                        end
                        OP_REQ: begin
                            case (r_phase)
                                PH_GREET: begin
                                    n_is_greet = 1'b1;
                                    n_len      = GREET_LEN_W;
                                    n_cnt      = '0;
                                    o_acc_cmd  = '{op: ACC_CLR, operand: '0};
                                    n_state    = ST_COPY;
                                end
                                PH_WRITE: begin
                                    n_is_greet = 1'b0;
                                    n_len      = TX_LEN_W;
                                    n_cnt      = '0;
                                    o_acc_cmd  = '{op: ACC_CLR, operand: '0};
                                    n_state    = ST_COPY;
                                end
                                PH_READ: begin
                                    n_ft      = RX_TOTAL;
                                    n_bc      = '0;
                                    o_acc_cmd = '{op: ACC_CLR, operand: '0};
                                    n_phase   = PH_RECEIVING;
                                    n_p_act   = ACT_START_READ;
                                    n_p_addr  = 1'b1;
                                    n_p_ram   = 1'b0;
                                    n_p_stop  = 1'b0;
                                    n_state   = ST_EMIT;
                                end
                                default: begin
                                end
                            endcase
                        end
                        OP_TXRDY: begin
                            if (r_phase == PH_SENDING) begin
                                n_p_addr = 1'b0;
                                if (bc_p1 <= ft_x) begin
                                    // next frame byte, stop with the checksum byte
                                    o_ram_req.re    = 1'b1;
                                    o_ram_req.raddr = r_bc;
                                    n_p_act         = ACT_SEND;
                                    n_p_ram         = 1'b1;
                                    n_p_stop        = (bc_p1 == ft_x);
                                    n_bc            = bc_p1[FRAME_AW-1:0];
                                end else begin
                                    n_phase  = PH_READ;
                                    n_p_act  = ACT_DONE;
                                    n_p_ram  = 1'b0;
                                    n_p_stop = 1'b0;
                                end
                                n_state = ST_EMIT;
                            end
                        end
                        default: begin
                            if (r_phase == PH_RECEIVING) begin
                                if (bc_p2 < ft_x) begin
                                    o_ram_req.we    = 1'b1;
                                    o_ram_req.waddr = r_bc;
                                    o_ram_req.wdata = i_data;
                                    o_acc_cmd       = '{op: ACC_ADD, operand: i_data};
                                    n_bc            = bc_p1[FRAME_AW-1:0];
                                end else if (bc_p2 == ft_x) begin
                                    // last payload byte: fold into the expected checksum
                                    o_ram_req.we    = 1'b1;
                                    o_ram_req.waddr = r_bc;
                                    o_ram_req.wdata = i_data;
                                    o_acc_cmd       = '{op: ACC_ADD_INV, operand: i_data};
                                    n_bc            = bc_p1[FRAME_AW-1:0];
                                    n_p_act         = ACT_NONE;
                                    n_p_addr        = 1'b0;
                                    n_p_ram         = 1'b0;
                                    n_p_stop        = 1'b1;
                                    n_state         = ST_EMIT;
                                end else begin
                                    // checksum byte
                                    n_phase = PH_WRITE;
                                    if (i_data == i_acc_sum) begin
                                        n_cnt   = '0;
                                        n_state = ST_DELIV;
                                    end else begin
                                        n_p_act  = ACT_REJECT;
                                        n_p_addr = 1'b0;
                                        n_p_ram  = 1'b0;
                                        n_p_stop = 1'b0;
                                        n_state  = ST_EMIT;
                                    end
                                end
                            end
                        end
                    endcase
                end
            end

            // copy source bytes into the frame buffer and sum them
            ST_COPY: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = r_cnt;
                o_ram_req.wdata = src_byte;
                o_acc_cmd       = '{op: ACC_ADD, operand: src_byte};
                n_cnt           = r_cnt + FRAME_AW'(1);
                if (n_cnt == r_len) begin
                    n_state = ST_CKSUM;
                end
            end

            // append checksum, fetch first byte
            ST_CKSUM: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = r_len;
                o_ram_req.wdata = ~i_acc_sum;
                o_ram_req.re    = 1'b1;
                o_ram_req.raddr = '0;
                n_ft            = r_len + FRAME_AW'(1);
                n_bc            = FRAME_AW'(1);
                n_phase         = PH_SENDING;
                n_p_act         = ACT_START_WRITE;
                n_p_addr        = 1'b1;
                n_p_ram         = 1'b1;
                n_p_stop        = 1'b0;
                n_state         = ST_EMIT;
            end

            // hand the pending result to the output register
            ST_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_o_act  = r_p_act;
                    n_o_addr = r_p_addr ? i_dev_addr : '0;
                    n_o_byte = r_p_ram ? i_ram_rdata : '0;
                    n_o_stop = r_p_stop;
                    n_o_last = 1'b1;
                    n_state  = ST_IDLE;
                end
            end

            // delivery: read one buffered byte
            ST_DELIV: begin
                o_ram_req.re    = 1'b1;
                o_ram_req.raddr = r_cnt;
                n_state         = ST_DLOUT;
            end

            ST_DLOUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_o_act  = ACT_DELIVER;
                    n_o_byte = i_ram_rdata;
                    n_o_last = (r_cnt == RX_LAST);
                    if (r_cnt == RX_LAST) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_cnt   = r_cnt + FRAME_AW'(1);
                        n_state = ST_DELIV;
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // output valid bookkeeping
        if (out_load) begin
            n_o_valid = 1'b1;
        end else if (i_out_ready) begin
            n_o_valid = 1'b0;
        end else begin
            n_o_valid = r_o_valid;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_phase    <= PH_GREET;
            r_bc       <= '0;
            r_ft       <= '0;
            r_cnt      <= '0;
            r_len      <= '0;
            r_is_greet <= 1'b0;
            r_p_act    <= ACT_NONE;
            r_p_addr   <= 1'b0;
            r_p_ram    <= 1'b0;
            r_p_stop   <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_bc       <= n_bc;
            r_ft       <= n_ft;
            r_cnt      <= n_cnt;
            r_len      <= n_len;
            r_is_greet <= n_is_greet;
            r_p_act    <= n_p_act;
            r_p_addr   <= n_p_addr;
            r_p_ram    <= n_p_ram;
            r_p_stop   <= n_p_stop;
            r_o_valid  <= n_o_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_act  <= n_o_act;
            r_o_addr <= n_o_addr;
            r_o_byte <= n_o_byte;
            r_o_stop <= n_o_stop;
            r_o_last <= n_o_last;
        end
    end

    // outgoing payload writes
    always_ff @(posedge i_clk) begin
        if (pl_we) begin
            r_payload[i_index[TX_IW-1:0]] <= i_data;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_action       = r_o_act;
    assign o_bus_address  = r_o_addr;
    assign o_byte_out     = r_o_byte;
    assign o_stop_request = r_o_stop;
    assign o_last         = r_o_last;

endmodule

`default_nettype wire

[sv/checksummed_frame_link_master.sv]
// items: a load is handled in idle; an item with a single result waits in the emit state
// write request: payload copy plus checksum, the greeting or the TX_LEN-byte write payload
// delivery of a good read frame: RX_LEN bytes, one at a time, one frame-buffer read port
// throughput: one item at a time, the single shared adder and frame-buffer port set the pace
// reset: synchronous active low; greeting pending, device address 1, buffers not cleared
`default_nettype none

module checksummed_frame_link_master
    import csfl_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // configuration write channel: device_address
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [ADDR_W-1:0]   i_cfg_data,
    // input stream
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [15:0]         s_axis_tdata,  // index[4:0], data[12:5], zero fill
    input  wire logic [OP_W-1:0]     s_axis_tuser,  // op[1:0]
    // result stream
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic      [15:0]         m_axis_tdata,  // bus_address[6:0], byte_out[14:7], stop[15]
    output logic      [ACT_W-1:0]    m_axis_tuser,  // action[2:0]
    output logic                     m_axis_tlast
);

    logic [ADDR_W-1:0] r_dev_addr;
    t_acc_cmd          acc_cmd;
    logic [BYTE_W-1:0] acc_sum;
    t_ram_req          ram_req;
    logic [BYTE_W-1:0] ram_rdata;
    t_act              action;
    logic [ADDR_W-1:0] bus_address;
    logic [BYTE_W-1:0] byte_out;
    logic              stop_request;

    // device address register, writable any time
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= ADDR_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_dev_addr <= i_cfg_data;
        end
    end

    csfl_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (s_axis_tvalid),
        .o_in_ready     (s_axis_tready),
        .i_op           (t_op'(s_axis_tuser)),
        .i_index        (s_axis_tdata[IDX_W-1:0]),
        .i_data         (s_axis_tdata[IDX_W+BYTE_W-1:IDX_W]),
        .i_dev_addr     (r_dev_addr),
        .o_acc_cmd      (acc_cmd),
        .i_acc_sum      (acc_sum),
        .o_ram_req      (ram_req),
        .i_ram_rdata    (ram_rdata),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_action       (action),
        .o_bus_address  (bus_address),
        .o_byte_out     (byte_out),
        .o_stop_request (stop_request),
        .o_last         (m_axis_tlast)
    );

    csfl_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (acc_cmd),
        .o_sum   (acc_sum)
    );

    csfl_frame_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    // result packing
    assign m_axis_tdata = {stop_request, byte_out, bus_address};
    assign m_axis_tuser = action;

endmodule

`default_nettype wire

[sv/csfl_checker.sv]
// port-level checks for the checksummed frame link master, bound to the top level
`default_nettype none

module csfl_checker
    import csfl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              m_axis_tvalid,
    input  wire logic              m_axis_tready,
    input  wire logic [15:0]       m_axis_tdata,
    input  wire logic [ACT_W-1:0]  m_axis_tuser,
    input  wire logic              m_axis_tlast
);

    // a stalled result beat stays up
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its data
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result data changed while stalled");

    // only delivery runs span more than one beat
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ACT_DELIVER) |-> m_axis_tlast)
        else $error("single result without last");

    // bus address only on start actions
    a_addr_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ACT_START_WRITE)
            && (m_axis_tuser != ACT_START_READ) |-> (m_axis_tdata[6:0] == 7'd0))
        else $error("bus address outside a start action");

    // stop requested only with a sent byte or the last received payload byte
    a_stop_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[15] |->
            (m_axis_tuser == ACT_SEND) || (m_axis_tuser == ACT_NONE))
        else $error("stop request on a wrong action");

endmodule

bind checksummed_frame_link_master csfl_checker u_csfl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

[sim/tb_checksummed_frame_link_master.sv]
// self-checking testbench for the checksummed frame link master: frame stimulus, link predictor
module tb_checksummed_frame_link_master;
    import csfl_pkg::*;

    localparam int WATCHDOG_CYCLES = 3000;
    localparam int SETTLE_CYCLES   = 60;
    localparam int HOLD_CYCLES     = 200;
    localparam int HOLD_AFTER      = 90;

    typedef struct {
        t_op               op;
        logic [IDX_W-1:0]  index;
        logic [BYTE_W-1:0] data;
    } t_link_beat;

    typedef struct {
        t_act              action;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] value;
        logic              stop;
        logic              ends_run;
    } t_link_result;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_valid   = 1'b0;
    logic [ADDR_W-1:0] i_cfg_data    = '0;
    logic              o_cfg_ready;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [15:0]       s_axis_tdata  = '0;
    logic [OP_W-1:0]   s_axis_tuser  = OP_LOAD;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [15:0]       m_axis_tdata;
    logic [ACT_W-1:0]  m_axis_tuser;
    logic              m_axis_tlast;

    // stimulus and expectation stores
    t_link_beat   beats_to_send[$];
    t_link_result awaited_results[$];
    t_link_beat   on_bus;

    // shadow copy of the link state
    t_phase            sh_phase;
    logic [5:0]        sh_count;
    logic [5:0]        sh_total;
    logic [7:0]        sh_sum;
    logic [7:0]        sh_frame [FRAME_DEPTH];
    logic [7:0]        sh_payload [TX_LEN];
    logic [ADDR_W-1:0] sh_addr;

    int  errors      = 0;
    int  planned     = 0;
    int  beats_in    = 0;
    int  beats_out   = 0;
    int  delivered   = 0;
    int  rejected    = 0;
    int  writes_done = 0;
    int  cfg_writes  = 0;
    int  idle_cycles = 0;
    int  tx_gap      = 0;
    bit  tx_quiet    = 1'b0;
    int  rx_wait     = 0;
    bit  rx_quiet    = 1'b0;
    int  rx_taken    = 0;
    int  hold_left   = 0;
    bit  hold_done   = 1'b0;
    bit  write_next  = 1'b0;

    checksummed_frame_link_master i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // index[4:0], data[12:5], zero fill
        .s_axis_tuser  (s_axis_tuser),   // op[1:0]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // bus_address[6:0], byte_out[14:7], stop[15]
        .m_axis_tuser  (m_axis_tuser),   // action[2:0]
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    task automatic flag_error(string msg);
        if (errors < 10) begin
            $display("ERROR: %s", msg);
        end
        errors++;
    endtask

    task automatic add_expect(t_act act, logic [ADDR_W-1:0] addr, logic [7:0] value,
                              logic stop, logic ends_run);
        t_link_result r;
        r.action   = act;
        r.addr     = addr;
        r.value    = value;
        r.stop     = stop;
        r.ends_run = ends_run;
        awaited_results.push_back(r);
    endtask

    // link behavior for one accepted input beat
    task automatic step_link(t_link_beat b);
        int         len;
        logic [7:0] sum;
        logic [7:0] nxt;
        case (b.op)
            OP_LOAD: begin
                if (int'(b.index) < TX_LEN) begin
                    sh_payload[b.index] = b.data;
                end
            end
            OP_REQ: begin
                if (sh_phase == PH_GREET || sh_phase == PH_WRITE) begin
                    len = (sh_phase == PH_GREET) ? GREET_LEN : TX_LEN;
                    sum = '0;
                    for (int i = 0; i < len; i++) begin
                        if (sh_phase == PH_GREET) begin
                            nxt = GREETING[i];
                        end else begin
                            nxt = sh_payload[i];
                        end
                        sh_frame[i] = nxt;
                        sum = sum + nxt;
                    end
                    sh_frame[len] = ~sum;
                    sh_total = 6'(len + 1);
                    sh_count = 6'd1;
                    sh_sum   = '0;
                    sh_phase = PH_SENDING;
                    add_expect(ACT_START_WRITE, sh_addr, sh_frame[0], 1'b0, 1'b1);
                end else if (sh_phase == PH_READ) begin
                    sh_total = 6'(RX_LEN + 1);
                    sh_count = '0;
                    sh_sum   = '0;
                    sh_phase = PH_RECEIVING;
                    add_expect(ACT_START_READ, sh_addr, 8'h00, 1'b0, 1'b1);
                end
            end
            OP_TXRDY: begin
                if (sh_phase == PH_SENDING) begin
                    if (int'(sh_count) + 1 <= int'(sh_total)) begin
                        add_expect(ACT_SEND, '0, sh_frame[sh_count],
                                   int'(sh_count) + 1 == int'(sh_total), 1'b1);
                        sh_count = sh_count + 6'd1;
                    end else begin
                        // checksum already out: frame closes, read comes next
                        sh_phase = PH_READ;
                        add_expect(ACT_DONE, '0, 8'h00, 1'b0, 1'b1);
                    end
                end
            end
            default: begin
                if (sh_phase == PH_RECEIVING) begin
                    if (int'(sh_count) + 2 <= int'(sh_total)) begin
                        sh_frame[sh_count] = b.data;
                        if (int'(sh_count) + 2 == int'(sh_total)) begin
                            // last payload byte: checksum target ready, ask for stop
                            sh_sum = ~(sh_sum + b.data);
                            add_expect(ACT_NONE, '0, 8'h00, 1'b1, 1'b1);
                        end else begin
                            sh_sum = sh_sum + b.data;
                        end
                        sh_count = sh_count + 6'd1;
                    end else begin
                        sh_phase = PH_WRITE;
                        if (b.data == sh_sum) begin
                            for (int i = 0; i < RX_LEN; i++) begin
                                add_expect(ACT_DELIVER, '0, sh_frame[i], 1'b0, i == RX_LEN - 1);
                            end
                        end else begin
                            add_expect(ACT_REJECT, '0, 8'h00, 1'b0, 1'b1);
                        end
                    end
                end
            end
        endcase
    endtask

    task automatic add_item(t_op op, int idx, int val, bit counted);
        t_link_beat b;
        b.op    = op;
        b.index = idx[IDX_W-1:0];
        b.data  = val[BYTE_W-1:0];
        beats_to_send.push_back(b);
        if (counted) begin
            planned++;
        end
    endtask

    // a beat that leaves the link phase alone in the given context (a load may still change the payload)
    task automatic add_stray(bit sending, bit receiving);
        t_op op;
        do begin
            op = t_op'($urandom_range(0, 3));
        end while (!(op == OP_LOAD || (op == OP_REQ && (sending || receiving)) ||
                     (op == OP_TXRDY && !sending) || (op == OP_RXBYTE && !receiving)));
        add_item(op, $urandom_range(0, 31), $urandom_range(0, 255), 1'b0);
    endtask

    task automatic queue_write_frame(int len, int noise);
        add_item(OP_REQ, $urandom_range(0, 31), $urandom_range(0, 255), 1'b1);
        for (int i = 0; i <= len; i++) begin
            if (noise != 0 && $urandom_range(1, noise) == 1) begin
                add_stray(1'b1, 1'b0);
            end
            add_item(OP_TXRDY, $urandom_range(0, 31), $urandom_range(0, 255), 1'b1);
        end
    endtask

    // fill below zero means random payload bytes
    task automatic queue_read_frame(bit good, int fill, int noise);
        logic [7:0] sum;
        logic [7:0] b;
        add_item(OP_REQ, $urandom_range(0, 31), $urandom_range(0, 255), 1'b1);
        sum = '0;
        for (int i = 0; i <= RX_LEN; i++) begin
            if (noise != 0 && $urandom_range(1, noise) == 1) begin
                add_stray(1'b0, 1'b1);
            end
            if (i == RX_LEN) begin
                b = good ? ~sum : (~sum ^ 8'($urandom_range(1, 255)));
            end else begin
                b = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
                sum = sum + b;
            end
            add_item(OP_RXBYTE, $urandom_range(0, 31), b, 1'b1);
        end
    endtask

    task automatic run_random(int target);
        int start;
        start = planned;
        while (planned - start < target) begin
            if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 4)) add_stray(1'b0, 1'b0);
            end
            if (write_next) begin
                queue_write_frame(TX_LEN, 6);
            end else begin
                queue_read_frame($urandom_range(0, 3) != 0, -1, 6);
            end
            write_next = !write_next;
        end
    endtask

    // sender holds back until everything is out and the block has settled
    task automatic wait_quiet();
        while (beats_to_send.size() != 0 || s_axis_tvalid || awaited_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_address(logic [ADDR_W-1:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sh_addr = v;
        cfg_writes++;
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                step_link(on_bus);
                beats_in++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (beats_to_send.size() != 0) begin
                    on_bus = beats_to_send.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {3'b000, on_bus.data, on_bus.index};
                    s_axis_tuser  <= on_bus.op;
                    if ($urandom_range(0, 15) == 0) begin
                        tx_quiet = !tx_quiet;
                    end
                    tx_gap = tx_quiet ? 0 : $urandom_range(0, 13);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result ready with per-beat stalls and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                rx_taken++;
                if ($urandom_range(0, 15) == 0) begin
                    rx_quiet = !rx_quiet;
                end
                rx_wait = rx_quiet ? 0 : $urandom_range(0, 13);
            end
            if (!hold_done && rx_taken >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_link_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            beats_out++;
            if (m_axis_tlast && m_axis_tuser == ACT_DELIVER) delivered++;
            if (m_axis_tuser == ACT_REJECT) rejected++;
            if (m_axis_tuser == ACT_DONE) writes_done++;
            if (awaited_results.size() == 0) begin
                flag_error($sformatf("result beat %0d arrived with none awaited: act %0d data %h",
                                     beats_out, m_axis_tuser, m_axis_tdata));
            end else begin
                want = awaited_results.pop_front();
                if (m_axis_tuser != want.action || m_axis_tdata[6:0] != want.addr ||
                    m_axis_tdata[14:7] != want.value || m_axis_tdata[15] != want.stop ||
                    m_axis_tlast != want.ends_run) begin
                    flag_error($sformatf({"result beat %0d: expected act %0d addr %h byte %h ",
                                          "stop %b last %b, got act %0d addr %h byte %h ",
                                          "stop %b last %b"},
                                         beats_out, want.action, want.addr, want.value,
                                         want.stop, want.ends_run, m_axis_tuser,
                                         m_axis_tdata[6:0], m_axis_tdata[14:7],
                                         m_axis_tdata[15], m_axis_tlast));
                end
            end
        end
    end

    // watchdog on stretches with no handshake at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("Timeout after %0d idle cycles", idle_cycles);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus sequence
    initial begin
        sh_phase = PH_GREET;
        sh_count = '0;
        sh_total = '0;
        sh_sum   = '0;
        sh_addr  = ADDR_W'(1);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_address(7'h7F);

        // payload extremes, out-of-range loads, strays before the greeting
        add_item(OP_LOAD, 0, 8'h00, 1'b1);
        add_item(OP_LOAD, TX_LEN - 1, 8'hFF, 1'b1);
        for (int i = 1; i < TX_LEN - 1; i++) begin
            add_item(OP_LOAD, i, $urandom_range(0, 255), 1'b1);
        end
        add_item(OP_LOAD, TX_LEN, 8'h5A, 1'b1);
        add_item(OP_LOAD, 31, 8'hA5, 1'b1);
        add_item(OP_TXRDY, 0, 0, 1'b1);
        add_item(OP_RXBYTE, 31, 8'hFF, 1'b1);
        // greeting, with a request while it is in flight and a ready after it closes
        add_item(OP_REQ, 0, 0, 1'b1);
        add_item(OP_REQ, 31, 8'hFF, 1'b1);
        for (int i = 0; i < GREET_LEN + 1; i++) begin
            add_item(OP_TXRDY, $urandom_range(0, 31), $urandom_range(0, 255), 1'b1);
        end
        add_item(OP_TXRDY, 0, 0, 1'b1);
        queue_read_frame(1'b1, 8'hFF, 0);
        add_item(OP_RXBYTE, 0, 8'h00, 1'b1);
        wait_quiet();

        write_address(7'h00);
        queue_write_frame(TX_LEN, 0);
        queue_read_frame(1'b0, 8'h00, 0);
        write_next = 1'b1;
        run_random(30);
        wait_quiet();

        write_address(ADDR_W'($urandom_range(0, 127)));
        run_random(30);
        wait_quiet();

        write_address(ADDR_W'($urandom_range(1, 126)));
        run_random(30);
        wait_quiet();

        if (awaited_results.size() != 0) begin
            flag_error($sformatf("%0d results never arrived", awaited_results.size()));
        end
        $display("Run: %0d input beats, %0d result beats, %0d address writes",
                 beats_in, beats_out, cfg_writes);
        $display("Frames: %0d write frames closed, %0d reads delivered, %0d reads rejected",
                 writes_done, delivered, rejected);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[files.f]
sv/csfl_pkg.sv
sv/csfl_frame_ram.sv
sv/csfl_accum.sv
sv/csfl_ctrl.sv
sv/checksummed_frame_link_master.sv
sv/csfl_checker.sv
sim/tb_checksummed_frame_link_master.sv
